[src/dumt_pkg.sv]
// Package: shared widths, operand codes and the queued item type of the def/use mark table.
`default_nettype none

package dumt_pkg;

  // Table and id sizing
  localparam int MAX_ENTRIES = 32;
  localparam int ID_WIDTH    = 16;
  localparam int CAP_W       = 6;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // Capacity register value after reset
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(32);

  // Depth of the queue between front and back
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Operand slots, handled in this order
  localparam int NUM_OPS  = 3;
  localparam int OP_DEST  = 0;
  localparam int OP_SRC_A = 1;
  localparam int OP_SRC_B = 2;

  // One classified instruction as it waits in the queue
  typedef struct packed {
    logic [NUM_OPS-1:0]               op_mask;
    logic [NUM_OPS-1:0][ID_WIDTH-1:0] op_id;
    logic                             last;
  } instr_t;

endpackage

`default_nettype wire

[src/dumt_in_if.sv]
// Interface: instruction channel into the def/use mark table.
`default_nettype none

interface dumt_in_if import dumt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                dest_valid;
  logic [ID_WIDTH-1:0] dest_id;
  logic                src_a_valid;
  logic [ID_WIDTH-1:0] src_a_id;
  logic                src_b_valid;
  logic [ID_WIDTH-1:0] src_b_id;
  logic                last_instr;

  modport source (
    output valid, dest_valid, dest_id, src_a_valid, src_a_id, src_b_valid, src_b_id,
           last_instr,
    input  ready
  );

  modport sink (
    input  valid, dest_valid, dest_id, src_a_valid, src_a_id, src_b_valid, src_b_id,
           last_instr,
    output ready
  );
endinterface

`default_nettype wire

[src/dumt_out_if.sv]
// Interface: entry report channel out of the def/use mark table.
`default_nettype none

interface dumt_out_if import dumt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ID_WIDTH-1:0] var_id;
  logic                def_mark;
  logic                is_used;
  logic                overflowed;
  logic                last_entry;

  modport source (
    output valid, var_id, def_mark, is_used, overflowed, last_entry,
    input  ready
  );

  modport sink (
    input  valid, var_id, def_mark, is_used, overflowed, last_entry,
    output ready
  );
endinterface

`default_nettype wire

[src/dumt_front.sv]
// Front end: accepts instruction items, classifies their operands and feeds the queue.
`default_nettype none

module dumt_front import dumt_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dumt_in_if.sink   in_i,
  output instr_t    q_data_o,
  output logic      q_push_o,
  input  wire logic q_full_i
);

  instr_t hold_q;
  logic   hold_valid_q;
  instr_t classified;
  logic   take;

  // Sort the operands into slots in processing order
  always_comb begin
    classified                   = '0;
    classified.op_mask[OP_DEST]  = in_i.dest_valid;
    classified.op_mask[OP_SRC_A] = in_i.src_a_valid;
    classified.op_mask[OP_SRC_B] = in_i.src_b_valid;
    classified.op_id[OP_DEST]    = in_i.dest_id;
    classified.op_id[OP_SRC_A]   = in_i.src_a_id;
    classified.op_id[OP_SRC_B]   = in_i.src_b_id;
    classified.last              = in_i.last_instr;
  end

  // Push the held item as soon as the queue has room
  assign q_push_o   = hold_valid_q && !q_full_i;
  assign in_i.ready = !hold_valid_q || !q_full_i;
  assign take       = in_i.valid && in_i.ready;
  assign q_data_o   = hold_q;

  // Hold one classified item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      hold_q       <= '0;
    end else begin
      if (take) begin
        hold_valid_q <= 1'b1;
        hold_q       <= classified;
      end else if (q_push_o) begin
        hold_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[src/dumt_fifo.sv]
// Short queue of classified items between the front and back ends.
`default_nettype none

module dumt_fifo import dumt_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire instr_t push_data_i,
  output logic        full_o,
  input  wire logic   pop_i,
  output logic        valid_o,
  output instr_t      pop_data_o
);

  instr_t              slot_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q;
  logic [QPTR_W-1:0]   rd_ptr_q;
  logic [QCNT_W-1:0]   fill_q;
  logic                do_push;
  logic                do_pop;

  assign full_o     = (fill_q == QCNT_W'(QDEPTH));
  assign valid_o    = (fill_q != '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;
  assign pop_data_o = slot_q[rd_ptr_q];

  // Store pushed items
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[src/dumt_back.sv]
// Back end: associative mark table, one operand lookup per cycle while marking, and the entry dump.
`default_nettype none

module dumt_back import dumt_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CAP_W-1:0] cfg_wdata_i,
  input  wire logic             q_valid_i,
  input  wire instr_t           q_data_i,
  output logic                  q_pop_o,
  dumt_out_if.source            out_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MARK,
    ST_DUMP
  } state_e;

  state_e              state_q;
  instr_t              cur_q;
  logic [CNT_W-1:0]    count_q;
  logic                drop_q;
  logic [CAP_W-1:0]    cap_q;
  logic [IDX_W-1:0]    dump_idx_q;

  logic                out_valid_q;
  logic [ID_WIDTH-1:0] out_id_q;
  logic                out_def_q;
  logic                out_used_q;
  logic                out_ovf_q;
  logic                out_last_q;

  // Table storage, flip-flops compared in parallel
  logic [ID_WIDTH-1:0] ids_q  [MAX_ENTRIES];
  logic                def_q  [MAX_ENTRIES];
  logic                used_q [MAX_ENTRIES];

  logic [NUM_OPS-1:0]     sel_oh;
  logic [NUM_OPS-1:0]     mask_nxt;
  logic [ID_WIDTH-1:0]    sel_id;
  logic                   as_dest;
  logic [MAX_ENTRIES-1:0] hit;
  logic                   hit_any;
  logic [IDX_W-1:0]       hit_idx;
  logic                   room_ok;
  logic                   do_op;
  logic                   append;
  logic                   drop_now;
  logic                   finish;
  logic [CNT_W-1:0]       count_after;
  logic [IDX_W-1:0]       app_idx;
  logic                   load;
  logic                   is_last;

  // Pick the lowest pending operand
  always_comb begin
    sel_oh   = cur_q.op_mask & (~cur_q.op_mask + 1'b1);
    mask_nxt = cur_q.op_mask & ~sel_oh;
    sel_id   = '0;
    for (int i = 0; i < NUM_OPS; i++) begin
      if (sel_oh[i]) begin
        sel_id = sel_id | cur_q.op_id[i];
      end
    end
    as_dest = sel_oh[OP_DEST];
  end

  // Compare the id against every filled entry
  always_comb begin
    hit_idx = '0;
    for (int k = 0; k < MAX_ENTRIES; k++) begin
      hit[k] = (CNT_W'(k) < count_q) && (ids_q[k] == sel_id);
      if (hit[k]) begin
        hit_idx = hit_idx | IDX_W'(k);
      end
    end
    hit_any = |hit;
  end

  // Decide between hit, append and drop
  assign room_ok     = (CMP_W'(count_q) < CMP_W'(cap_q)) &&
                       (count_q < CNT_W'(MAX_ENTRIES));
  assign do_op       = (state_q == ST_MARK) && (cur_q.op_mask != '0);
  assign append      = do_op && !hit_any && room_ok;
  assign drop_now    = do_op && !hit_any && !room_ok;
  assign finish      = (state_q == ST_MARK) && (mask_nxt == '0);
  assign count_after = append ? count_q + 1'b1 : count_q;
  assign app_idx     = count_q[IDX_W-1:0];

  // Dump one entry whenever the output register is free
  assign load    = (state_q == ST_DUMP) && (!out_valid_q || out_o.ready);
  assign is_last = ((CNT_W'(dump_idx_q) + 1'b1) == count_q);
  assign q_pop_o = (state_q == ST_IDLE) && q_valid_i;

  // Update ids and marks
  always_ff @(posedge clk_i) begin
    if (append) begin
      ids_q[app_idx]  <= sel_id;
      def_q[app_idx]  <= as_dest;
      used_q[app_idx] <= !as_dest;
    end
    if (do_op && hit_any) begin
      if (as_dest) begin
        def_q[hit_idx] <= 1'b1;
      end else begin
        used_q[hit_idx] <= 1'b1;
      end
    end
  end

  // Sequencer state, count, flags and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_q       <= '0;
      count_q     <= '0;
      drop_q      <= 1'b0;
      cap_q       <= CAP_RESET;
      dump_idx_q  <= '0;
      out_valid_q <= 1'b0;
      out_id_q    <= '0;
      out_def_q   <= 1'b0;
      out_used_q  <= 1'b0;
      out_ovf_q   <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (out_valid_q && out_o.ready && !load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (q_pop_o) begin
            cur_q   <= q_data_i;
            state_q <= ST_MARK;
          end
        end
        ST_MARK: begin
          cur_q.op_mask <= mask_nxt;
          count_q       <= count_after;
          if (finish && cur_q.last && (count_after == '0)) begin
            // Empty table on the final item: report nothing, drop the flag
            drop_q  <= 1'b0;
            state_q <= ST_IDLE;
          end else begin
            if (drop_now) begin
              drop_q <= 1'b1;
            end
            if (finish) begin
              if (cur_q.last) begin
                dump_idx_q <= '0;
                state_q    <= ST_DUMP;
              end else begin
                state_q <= ST_IDLE;
              end
            end
          end
        end
        ST_DUMP: begin
          if (load) begin
            out_valid_q <= 1'b1;
            out_id_q    <= ids_q[dump_idx_q];
            out_def_q   <= def_q[dump_idx_q];
            out_used_q  <= used_q[dump_idx_q];
            out_ovf_q   <= drop_q;
            out_last_q  <= is_last;
            if (is_last) begin
              count_q <= '0;
              drop_q  <= 1'b0;
              state_q <= ST_IDLE;
            end else begin
              dump_idx_q <= dump_idx_q + 1'b1;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.var_id     = out_id_q;
  assign out_o.def_mark   = out_def_q;
  assign out_o.is_used    = out_used_q;
  assign out_o.overflowed = out_ovf_q;
  assign out_o.last_entry = out_last_q;

  // Fill count never passes the table size
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_ENTRIES))
    else $error("entry count above table size");

  // Ids in the table are unique, so at most one entry hits
  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_op |-> $onehot0(hit))
    else $error("more than one table entry hit");

  // A dump only runs over a non-empty table
  a_dump_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DUMP) |-> (count_q != '0))
    else $error("dump with empty table");

  // The final entry of a dump leaves the table empty and the flag clear
  a_dump_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && is_last) |=> (count_q == '0) && !drop_q && (state_q == ST_IDLE))
    else $error("table not emptied after dump");

endmodule

`default_nettype wire

[src/def_use_mark_table.sv]
// Top level of the def/use mark table: front end, item queue and back end.
//
// Usage:
//   in_i carries one instruction per item: an optional destination id and two
//   optional source ids, plus last_instr on the final instruction of a function.
//   out_o carries one item per table entry, in insertion order, after an item
//   with last_instr; last_entry marks the final one. An empty table reports nothing.
//   cfg_we_i / cfg_wdata_i write the capacity register (reset 32) while idle.
// Flow:
//   The front end holds one item and hands it to a two-entry queue. The back end
//   looks up one operand per cycle in a parallel-compare table; it pops an item
//   only while idle, so it takes no new item before the last one is marked.
//   After the last operand of the final instruction is looked up, the back end
//   enters the dump state, which registers the entries one after another into
//   the output register, loading one whenever that register is empty or taken.
// Reset:
//   The table is empty, the overflow flag clear and the capacity back to 32.
// Stalls:
//   A report waits in the output register while out_o.ready is low; the dump
//   pauses, the queue fills and in_i.ready drops once queue and front are full.
`default_nettype none

module def_use_mark_table import dumt_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CAP_W-1:0] cfg_wdata_i,
  dumt_in_if.sink               in_i,
  dumt_out_if.source            out_o
);

  instr_t push_data;
  logic   push;
  logic   full;
  instr_t pop_data;
  logic   pop;
  logic   q_valid;

  // Accept and classify
  dumt_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_data_o (push_data),
    .q_push_o (push),
    .q_full_i (full)
  );

  // Decouple front and back
  dumt_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_data)
  );

  // Mark and dump
  dumt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (q_valid),
    .q_data_i    (pop_data),
    .q_pop_o     (pop),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Testbench for the def/use mark table: directed rows, then random functions.
`timescale 1ns / 1ps

module tb_top import dumt_pkg::*; ();

  // Run limits
  localparam int CYCLE_LIMIT   = 800000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 37;
  localparam int MAX_SHOWN     = 10;

  // One instruction as driven on the input channel
  typedef struct packed {
    logic                dest_valid;
    logic [ID_WIDTH-1:0] dest_id;
    logic                src_a_valid;
    logic [ID_WIDTH-1:0] src_a_id;
    logic                src_b_valid;
    logic [ID_WIDTH-1:0] src_b_id;
    logic                last_instr;
  } instr_item_t;

  localparam int INSTR_W = $bits(instr_item_t);

  // One reported table entry
  typedef struct packed {
    logic [ID_WIDTH-1:0] var_id;
    logic                def_mark;
    logic                is_used;
    logic                overflowed;
    logic                last_entry;
  } mark_report_t;

  // Directed row kinds: capacity write, predicted, no report, one typed report
  typedef enum bit [1:0] {ROW_CFG, ROW_PRED, ROW_NONE, ROW_ONE} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [CAP_W-1:0]  cap;
    instr_item_t       instr;
    mark_report_t      report;
  } dir_row_t;

  typedef enum bit [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic [CAP_W-1:0] cap;
    idle_mode_e       mode;
    bit               hold;
  } phase_t;

  localparam instr_item_t  NO_INSTR  = '0;
  localparam mark_report_t NO_REPORT = '0;

  localparam int DIR_ROWS = 24;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    // empty table on a last item
    '{ROW_NONE, 6'd0, '{1'b0, 16'h0000, 1'b0, 16'h0000, 1'b0, 16'h0000, 1'b1}, NO_REPORT},
    // all-ones id in every slot, later slots hit the new entry
    '{ROW_ONE,  6'd0, '{1'b1, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1},
      '{16'hFFFF, 1'b1, 1'b1, 1'b0, 1'b1}},
    '{ROW_ONE,  6'd0, '{1'b1, 16'h0000, 1'b0, 16'h0000, 1'b0, 16'h0000, 1'b1},
      '{16'h0000, 1'b1, 1'b0, 1'b0, 1'b1}},
    '{ROW_ONE,  6'd0, '{1'b0, 16'hFFFF, 1'b1, 16'h0000, 1'b0, 16'hFFFF, 1'b1},
      '{16'h0000, 1'b0, 1'b1, 1'b0, 1'b1}},
    '{ROW_ONE,  6'd0, '{1'b0, 16'h5555, 1'b0, 16'h5555, 1'b1, 16'hAAAA, 1'b1},
      '{16'hAAAA, 1'b0, 1'b1, 1'b0, 1'b1}},
    '{ROW_PRED, 6'd0, '{1'b1, 16'h5555, 1'b1, 16'h5555, 1'b1, 16'h1234, 1'b0}, NO_REPORT},
    '{ROW_PRED, 6'd0, '{1'b1, 16'h0007, 1'b1, 16'h1234, 1'b1, 16'h8000, 1'b1}, NO_REPORT},
    '{ROW_PRED, 6'd0, '{1'b1, 16'h8000, 1'b1, 16'h7FFF, 1'b1, 16'h0001, 1'b0}, NO_REPORT},
    '{ROW_PRED, 6'd0, '{1'b1, 16'h0001, 1'b1, 16'h7FFF, 1'b1, 16'h7FFF, 1'b1}, NO_REPORT},
    // one entry only: later misses drop and raise the flag
    '{ROW_CFG,  6'd1, NO_INSTR, NO_REPORT},
    '{ROW_ONE,  6'd0, '{1'b1, 16'h000A, 1'b1, 16'h000B, 1'b1, 16'h000C, 1'b1},
      '{16'h000A, 1'b1, 1'b0, 1'b1, 1'b1}},
    '{ROW_PRED, 6'd0, '{1'b1, 16'h0014, 1'b1, 16'h0014, 1'b0, 16'h0000, 1'b0}, NO_REPORT},
    '{ROW_ONE,  6'd0, '{1'b0, 16'h0000, 1'b0, 16'h0000, 1'b1, 16'h0015, 1'b1},
      '{16'h0014, 1'b1, 1'b1, 1'b1, 1'b1}},
    // zero capacity: everything drops, the dump is empty and the flag is lost
    '{ROW_CFG,  6'd0, NO_INSTR, NO_REPORT},
    '{ROW_PRED, 6'd0, '{1'b1, 16'h0001, 1'b1, 16'h0002, 1'b0, 16'h0000, 1'b0}, NO_REPORT},
    '{ROW_NONE, 6'd0, '{1'b1, 16'h0003, 1'b0, 16'h0000, 1'b0, 16'h0000, 1'b1}, NO_REPORT},
    '{ROW_NONE, 6'd0, '{1'b0, 16'h0000, 1'b0, 16'h0000, 1'b0, 16'h0000, 1'b1}, NO_REPORT},
    // lower the capacity below the fill level in the middle of a function
    '{ROW_CFG,  6'd2, NO_INSTR, NO_REPORT},
    '{ROW_PRED, 6'd0, '{1'b1, 16'h0030, 1'b1, 16'h0031, 1'b1, 16'h0032, 1'b0}, NO_REPORT},
    '{ROW_CFG,  6'd1, NO_INSTR, NO_REPORT},
    '{ROW_PRED, 6'd0, '{1'b0, 16'h0000, 1'b1, 16'h0030, 1'b1, 16'h0033, 1'b1}, NO_REPORT},
    // capacity above the table size
    '{ROW_CFG,  6'd63, NO_INSTR, NO_REPORT},
    '{ROW_PRED, 6'd0, '{1'b1, 16'h00FF, 1'b1, 16'h00FF, 1'b1, 16'h00FF, 1'b1}, NO_REPORT},
    '{ROW_NONE, 6'd0, '{1'b0, 16'h0000, 1'b0, 16'h0000, 1'b0, 16'h0000, 1'b1}, NO_REPORT}
  };

  localparam int NUM_PHASES = 9;
  localparam phase_t PHASES [NUM_PHASES] = '{
    '{6'd32, IDLE_NONE, 1'b0},
    '{6'd32, IDLE_NONE, 1'b1},
    '{6'd1,  IDLE_SEND, 1'b0},
    '{6'd63, IDLE_RECV, 1'b0},
    '{6'd5,  IDLE_BOTH, 1'b0},
    '{6'd17, IDLE_RECV, 1'b0},
    '{6'd2,  IDLE_BOTH, 1'b0},
    '{6'd32, IDLE_SEND, 1'b0},
    '{6'd63, IDLE_BOTH, 1'b0}
  };

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CAP_W-1:0] cfg_wdata_i;

  dumt_in_if  in_if ();
  dumt_out_if out_if ();

  def_use_mark_table dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // Predicted table state
  logic [ID_WIDTH-1:0] tab_id  [MAX_ENTRIES];
  bit                  tab_def [MAX_ENTRIES];
  bit                  tab_use [MAX_ENTRIES];
  int unsigned         tab_cnt  = 0;
  bit                  tab_drop = 1'b0;
  logic [CAP_W-1:0]    tab_cap  = CAP_RESET;

  mark_report_t expected_reports [$];

  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  bit          hold_go        = 1'b0;
  logic        rx_hold        = 1'b0;
  int unsigned err_count      = 0;
  int unsigned cycle_cnt      = 0;

  // Random function generator state
  logic [ID_WIDTH-1:0] id_pool [48];
  int unsigned         pool_n  = 1;
  int unsigned         fn_left = 0;

  // Mark one id in the predicted table: hit sets a mark, miss appends or drops
  function automatic void mark_var(logic [ID_WIDTH-1:0] id, bit as_dest);
    int unsigned room;
    room = (int'(tab_cap) > MAX_ENTRIES) ? MAX_ENTRIES : int'(tab_cap);
    for (int k = 0; k < tab_cnt; k++) begin
      if (tab_id[k] == id) begin
        if (as_dest) tab_def[k] = 1'b1;
        else tab_use[k] = 1'b1;
        return;
      end
    end
    if (tab_cnt < room) begin
      tab_id[tab_cnt]  = id;
      tab_def[tab_cnt] = as_dest;
      tab_use[tab_cnt] = !as_dest;
      tab_cnt++;
    end else begin
      tab_drop = 1'b1;
    end
  endfunction

  // Advance the predicted table by one instruction; queue the dump if asked
  function automatic void apply_instr(instr_item_t it, bit queue_dump);
    if (it.dest_valid) mark_var(it.dest_id, 1'b1);
    if (it.src_a_valid) mark_var(it.src_a_id, 1'b0);
    if (it.src_b_valid) mark_var(it.src_b_id, 1'b0);
    if (it.last_instr) begin
      if (queue_dump) begin
        for (int k = 0; k < tab_cnt; k++) begin
          expected_reports.push_back('{tab_id[k], tab_def[k], tab_use[k], tab_drop,
                                       (k + 1 == tab_cnt)});
        end
      end
      tab_cnt  = 0;
      tab_drop = 1'b0;
    end
  endfunction

  function automatic logic [ID_WIDTH-1:0] pool_id();
    if ($urandom_range(9) == 0) return ID_WIDTH'($urandom);
    return id_pool[$urandom_range(pool_n - 1)];
  endfunction

  // Offer one item, with random idle cycles ahead of it; return at acceptance
  task automatic send_instr(input instr_item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_if.valid       <= 1'b1;
    in_if.dest_valid  <= it.dest_valid;
    in_if.dest_id     <= it.dest_id;
    in_if.src_a_valid <= it.src_a_valid;
    in_if.src_a_id    <= it.src_a_id;
    in_if.src_b_valid <= it.src_b_valid;
    in_if.src_b_id    <= it.src_b_id;
    in_if.last_instr  <= it.last_instr;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // Write the capacity once the block has gone quiet
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    in_if.valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tab_cap = cap;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Give up after the cycle limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Drive the receiver: random stalls plus the long hold-off
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_if.ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Hold off the receiver for a long stretch once asked
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // Compare each accepted report with the oldest expected one
  always @(posedge clk_i) begin
    mark_report_t got;
    mark_report_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = '{out_if.var_id, out_if.def_mark, out_if.is_used, out_if.overflowed,
              out_if.last_entry};
      if (expected_reports.size() == 0) begin
        err_count++;
        if (err_count <= MAX_SHOWN)
          $display("cycle %0d: unexpected report id=%h def=%b used=%b ovf=%b last=%b",
                   cycle_cnt, got.var_id, got.def_mark, got.is_used, got.overflowed,
                   got.last_entry);
      end else begin
        want = expected_reports.pop_front();
        if (got !== want) begin
          err_count++;
          if (err_count <= MAX_SHOWN)
            $display({"cycle %0d: expected id=%h def=%b used=%b ovf=%b last=%b,",
                      " got id=%h def=%b used=%b ovf=%b last=%b"},
                     cycle_cnt, want.var_id, want.def_mark, want.is_used,
                     want.overflowed, want.last_entry, got.var_id, got.def_mark,
                     got.is_used, got.overflowed, got.last_entry);
        end
      end
    end
  end

  // Main stimulus
  initial begin
    instr_item_t it;
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_wdata_i       <= '0;
    in_if.valid       <= 1'b0;
    in_if.dest_valid  <= 1'b0;
    in_if.dest_id     <= '0;
    in_if.src_a_valid <= 1'b0;
    in_if.src_a_id    <= '0;
    in_if.src_b_valid <= 1'b0;
    in_if.src_b_id    <= '0;
    in_if.last_instr  <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed rows
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIR_TAB[r].kind == ROW_CFG) begin
        write_capacity(DIR_TAB[r].cap);
      end else begin
        send_instr(DIR_TAB[r].instr);
        apply_instr(DIR_TAB[r].instr, DIR_TAB[r].kind == ROW_PRED);
        if (DIR_TAB[r].kind == ROW_ONE) expected_reports.push_back(DIR_TAB[r].report);
      end
    end

    // Random functions, phase by phase
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_capacity(PHASES[p].cap);
      case (PHASES[p].mode)
        IDLE_NONE: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        IDLE_SEND: begin
          send_idle_pct  = 58;
          recv_stall_pct = 0;
        end
        IDLE_RECV: begin
          send_idle_pct  = 0;
          recv_stall_pct = 58;
        end
        default: begin
          send_idle_pct  = 31;
          recv_stall_pct = 31;
        end
      endcase
      if (PHASES[p].hold) hold_go = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Open a new function with a fresh pool of ids
        if (fn_left == 0) begin
          pool_n = ($urandom_range(7) == 0) ? 48 : $urandom_range(1, 24);
          foreach (id_pool[i]) id_pool[i] = ID_WIDTH'($urandom);
          fn_left = ($urandom_range(5) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 8);
        end
        if ($urandom_range(9) == 0) begin
          // Noise: every field random, a stray last breaks the function
          it = INSTR_W'({$urandom, $urandom});
        end else begin
          it.dest_valid  = ($urandom_range(99) < 75);
          it.dest_id     = pool_id();
          it.src_a_valid = ($urandom_range(99) < 70);
          it.src_a_id    = pool_id();
          it.src_b_valid = ($urandom_range(99) < 70);
          it.src_b_id    = pool_id();
          it.last_instr  = (fn_left == 1);
          fn_left--;
        end
        send_instr(it);
        apply_instr(it, 1'b1);
      end
    end

    // Drain and finish
    in_if.valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
